### rtl/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types and constants of the brush stroke rasteriser.
// ----------------------------------------------------------------------------
`default_nettype none

package bsr_pkg;

  localparam logic [7:0] PIX_FULL     = 8'd255;
  localparam logic [5:0] RADIUS_RESET = 6'd10;

  // Q16 centre and point coordinates, signed
  localparam int QW = 29;

  // shared divider
  localparam int DIV_NW = 26;
  localparam int DIV_DW = 10;

  localparam logic [2:0] REG_BRUSH_RADIUS = 3'd0;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic       start;
    logic [9:0] su;
    logic [9:0] sv;
    logic [9:0] eu;
    logic [9:0] ev;
    logic [5:0] radius;
  } pen_cmd_t;

endpackage

`default_nettype wire

### rtl/bsr_if.sv
// ----------------------------------------------------------------------------
// bsr_in_if / bsr_out_if
// Valid/ready channels of the rasteriser: command items in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [9:0] start_u;
  logic [9:0] start_v;
  logic [9:0] end_u;
  logic [9:0] end_v;
  logic [8:0] pixel_row;
  logic [8:0] pixel_col;
  modport source (output valid, op, start_u, start_v, end_u, end_v, pixel_row, pixel_col,
                  input ready);
  modport sink (input valid, op, start_u, start_v, end_u, end_v, pixel_row, pixel_col,
                output ready);
endinterface

interface bsr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;
  logic       is_read;
  modport source (output valid, pixel_value, is_read, input ready);
  modport sink (input valid, pixel_value, is_read, output ready);
endinterface

`default_nettype wire

### rtl/brush_stroke_rasterizer_top.sv
// ----------------------------------------------------------------------------
// brush_stroke_rasterizer_top
// Brush stroke rasteriser over an 8-bit FRAME_DIM x FRAME_DIM frame store.
// ----------------------------------------------------------------------------
// One command at a time. After reset, and for a clear command, a clearing
// pass writes one pixel a cycle over all FRAME_DIM*FRAME_DIM pixels, with
// no transfer taken in. A read returns the pixel, zero outside the frame.
// A draw runs a setup division when the end points differ, then a disk at
// each point of the longer axis, ends included: per midpoint iteration a
// shade division on the shared divider, per octant point a read, a write
// for an unfilled point inside the frame and one per pixel of its column
// fill, all bound by the single frame store write port. A finished result
// waits in the output register while the next command is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module brush_stroke_rasterizer_top
  import bsr_pkg::*;
#(
  parameter int FRAME_DIM = 512
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  bsr_in_if.sink           in_ch,
  bsr_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int CW    = $clog2(FRAME_DIM);
  localparam int DEPTH = FRAME_DIM * FRAME_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] FDA  = AW'(FRAME_DIM);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [10:0]   FD11 = 11'(FRAME_DIM);

  typedef enum logic [4:0] {
    T_CLEAR = 5'b00001,
    T_IDLE  = 5'b00010,
    T_DRAW  = 5'b00100,
    T_READ  = 5'b01000,
    T_RESP  = 5'b10000
  } top_state_t;

  top_state_t state_r;
  logic [AW-1:0] clr_r;
  logic          pend_r;
  logic          rd_ok_r;
  logic [7:0]    res_pix_r;
  logic          res_rd_r;
  logic          out_valid_r;
  logic [7:0]    out_pix_r;
  logic          out_rd_r;
  logic [5:0]    radius_r;

  logic          accept;
  logic          out_free;
  pen_cmd_t      pen_cmd;
  logic          pen_done;
  logic          pen_we;
  logic [AW-1:0] pen_waddr, pen_raddr, rd_addr;
  logic [7:0]    pen_wdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  assign pready      = 1'b1;
  assign prdata      = (paddr == REG_BRUSH_RADIUS) ? 32'(radius_r) : 32'd0;
  assign in_ch.ready = state_r == T_IDLE;
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    pen_cmd.start  = accept && op_t'(in_ch.op) == OP_DRAW;
    pen_cmd.su     = in_ch.start_u;
    pen_cmd.sv     = in_ch.start_v;
    pen_cmd.eu     = in_ch.end_u;
    pen_cmd.ev     = in_ch.end_v;
    pen_cmd.radius = radius_r;

    rd_addr = AW'(in_ch.pixel_row) * FDA + AW'(in_ch.pixel_col);
    if (state_r == T_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = 8'd0;
    end else begin
      mem_we    = pen_we;
      mem_waddr = pen_waddr;
      mem_wdata = pen_wdata;
    end
    mem_raddr = (state_r == T_DRAW) ? pen_raddr : rd_addr;
  end

  bsr_pen #(
    .FRAME_DIM (FRAME_DIM),
    .CW        (CW),
    .AW        (AW)
  ) u_pen (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (pen_cmd),
    .done      (pen_done),
    .mem_we    (pen_we),
    .mem_waddr (pen_waddr),
    .mem_wdata (pen_wdata),
    .mem_raddr (pen_raddr),
    .mem_rdata (mem_rdata)
  );

  bsr_frame_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (psel && penable && pwrite && paddr == REG_BRUSH_RADIUS) begin
      radius_r <= pwdata[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == T_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        T_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == LAST) begin
            state_r <= pend_r ? T_RESP : T_IDLE;
          end
        end
        T_IDLE: begin
          if (accept) begin
            unique case (op_t'(in_ch.op))
              OP_CLEAR: begin
                state_r <= T_CLEAR;
                clr_r   <= '0;
                pend_r  <= 1'b1;
              end
              OP_DRAW:  state_r <= T_DRAW;
              OP_READ:  state_r <= T_READ;
              OP_NONE:  state_r <= T_RESP;
              default:  state_r <= T_RESP;
            endcase
          end
        end
        T_DRAW: begin
          if (pen_done) begin
            state_r <= T_RESP;
          end
        end
        T_READ: begin
          state_r <= T_RESP;
        end
        T_RESP: begin
          if (out_free) begin
            state_r <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == T_IDLE && accept) begin
      res_pix_r <= 8'd0;
      res_rd_r  <= op_t'(in_ch.op) == OP_READ;
      rd_ok_r   <= (11'(in_ch.pixel_row) < FD11) && (11'(in_ch.pixel_col) < FD11);
    end
    if (state_r == T_READ) begin
      res_pix_r <= rd_ok_r ? mem_rdata : 8'd0;
    end
    if (state_r == T_RESP && out_free) begin
      out_pix_r <= res_pix_r;
      out_rd_r  <= res_rd_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_value = out_pix_r;
  assign out_ch.is_read     = out_rd_r;

endmodule

`default_nettype wire

### rtl/bsr_div.sv
// ----------------------------------------------------------------------------
// bsr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_div
  import bsr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_NW-1:0] dividend,
  input  wire logic [DIV_DW-1:0] divisor,
  output logic                   done,
  output logic      [DIV_NW-1:0] quot,
  output logic      [DIV_DW-1:0] rem
);

  localparam int CNTW = $clog2(DIV_NW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] dvs_r;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW:0]   diff;
  logic              ge;

  always_comb begin
    shifted = {rem_r, quo_r[DIV_NW-1]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = shifted >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= CNTW'(DIV_NW);
      end else if (busy_r) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= cnt_r == CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
      quo_r <= {quo_r[DIV_NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

### rtl/bsr_frame_store.sv
// ----------------------------------------------------------------------------
// bsr_frame_store
// Pixel memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_frame_store #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/bsr_pen.sv
// ----------------------------------------------------------------------------
// bsr_pen
// Segment stepper and disk stamper: read-modify-write of the frame store.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_pen
  import bsr_pkg::*;
#(
  parameter int FRAME_DIM = 512,
  parameter int CW        = 9,
  parameter int AW        = 18
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pen_cmd_t      cmd,
  output logic               done,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [7:0]         mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  wire logic [7:0]    mem_rdata
);

  typedef enum logic [8:0] {
    P_IDLE   = 9'b000000001,
    P_SEGDIV = 9'b000000010,
    P_STAMP  = 9'b000000100,
    P_SHST   = 9'b000001000,
    P_SHWAIT = 9'b000010000,
    P_PTRD   = 9'b000100000,
    P_PTCHK  = 9'b001000000,
    P_FILL   = 9'b010000000,
    P_NEXT   = 9'b100000000
  } pen_state_t;

  localparam logic signed [QW-1:0] FDQ  = QW'(FRAME_DIM * 65536);
  localparam logic [AW-1:0]        FDA  = AW'(FRAME_DIM);
  localparam logic signed [11:0]   FDM1 = 12'(FRAME_DIM - 1);
  localparam logic [12:0]          FD13 = 13'(FRAME_DIM);

  pen_state_t state_r;
  logic       done_r;

  // segment
  logic        vmaj_r, dir_neg_r, min_neg_r;
  logic [9:0]  dm_r, maj_r, smin_r, rem_r, ra_r;
  logic [10:0] left_r;
  logic [26:0] q_r;
  logic [16:0] qa_r;
  logic [5:0]  rad_r;

  // disk
  logic signed [QW-1:0] rc_r, cc_r;
  logic signed [11:0]   x_r, y_r, err_r;
  logic [2:0]           pt_r;
  logic [7:0]           shade_r;
  logic [CW-1:0]        prow_r;
  logic [AW-1:0]        paddr_r;
  logic signed [11:0]   fcol_r, fhi_r;

  // divider
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_nd, div_q;
  logic [DIV_DW-1:0] div_dv, div_r;

  // segment setup
  logic signed [10:0] du, dv;
  logic [9:0]         adu, adv, dm_c, dmin_c;
  logic               vmaj_c;

  // centre and step
  logic signed [QW-1:0] mq, maj_q, rc_c, cc_c;
  logic [10:0]          sum_rem;
  logic                 carry;

  // shade
  logic signed [11:0] n_sh;
  logic [DIV_NW-1:0]  nn;

  // midpoint update
  logic signed [11:0] y1, e1, x1, e2, xn, en;
  logic               xdec;

  // point
  logic signed [11:0] dr, dc, colv, tcv, lo_c, hi_c;
  logic signed [QW-1:0] row_s, col_s;
  logic [12:0]          rhi, chi;
  logic                 row_ok, col_ok;
  logic [CW-1:0]        row_i;
  logic [AW-1:0]        pt_addr, fill_addr;
  logic                 last_pt;

  bsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_nd),
    .divisor  (div_dv),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  always_comb begin
    du     = $signed({1'b0, cmd.eu}) - $signed({1'b0, cmd.su});
    dv     = $signed({1'b0, cmd.ev}) - $signed({1'b0, cmd.sv});
    adu    = du[10] ? 10'(-du) : du[9:0];
    adv    = dv[10] ? 10'(-dv) : dv[9:0];
    vmaj_c = adu < adv;
    dm_c   = vmaj_c ? adv : adu;
    dmin_c = vmaj_c ? adu : adv;

    n_sh = $signed({6'b0, rad_r}) - err_r;
    nn   = n_sh > 12'sd0 ? DIV_NW'(n_sh[10:0]) : '0;

    div_start = (state_r == P_IDLE && cmd.start && dm_c != 10'd0) || (state_r == P_SHST);
    if (state_r == P_IDLE) begin
      div_nd = {dmin_c, 16'b0};
      div_dv = dm_c;
    end else begin
      div_nd = (nn << 8) - nn;
      div_dv = DIV_DW'(rad_r);
    end

    maj_q = $signed({{(QW-26){1'b0}}, maj_r, 16'b0});
    if (min_neg_r) begin
      mq = $signed({{(QW-26){1'b0}}, smin_r, 16'b0}) - $signed({{(QW-27){1'b0}}, q_r});
    end else begin
      mq = $signed({{(QW-26){1'b0}}, smin_r, 16'b0}) + $signed({{(QW-27){1'b0}}, q_r});
    end
    rc_c = vmaj_r ? FDQ - maj_q : FDQ - mq;
    cc_c = vmaj_r ? mq : maj_q;

    sum_rem = {1'b0, rem_r} + {1'b0, ra_r};
    carry   = sum_rem >= {1'b0, dm_r};

    y1   = y_r + 12'sd1;
    e1   = err_r + 12'sd1 + (y1 <<< 1);
    xdec = (((e1 - x_r) <<< 1) + 12'sd1) > 12'sd0;
    x1   = x_r - 12'sd1;
    e2   = e1 + 12'sd1 - (x1 <<< 1);
    xn   = xdec ? x1 : x_r;
    en   = xdec ? e2 : e1;

    case (pt_r)
      3'd0:    begin dr = x_r;  dc = y_r;  end
      3'd1:    begin dr = y_r;  dc = x_r;  end
      3'd2:    begin dr = -y_r; dc = x_r;  end
      3'd3:    begin dr = -x_r; dc = y_r;  end
      3'd4:    begin dr = -x_r; dc = -y_r; end
      3'd5:    begin dr = -y_r; dc = -x_r; end
      3'd6:    begin dr = y_r;  dc = -x_r; end
      default: begin dr = x_r;  dc = -y_r; end
    endcase

    row_s = rc_r + (QW'(dr) <<< 16);
    col_s = cc_r + (QW'(dc) <<< 16);
    rhi   = row_s[QW-1:16];
    chi   = col_s[QW-1:16];
    row_ok = row_s[QW-1] ? ((&rhi) && row_s[15:0] != 16'd0) : (rhi < FD13);
    col_ok = col_s[QW-1] ? ((&chi) && col_s[15:0] != 16'd0) : (chi < FD13);
    row_i  = row_s[QW-1] ? '0 : rhi[CW-1:0];
    colv   = col_s[QW-1] ? 12'sd0 : $signed({1'b0, chi[10:0]});
    tcv    = $signed({2'b0, cc_r[25:16]});
    if (dc[11]) begin
      lo_c = colv + 12'sd1;
      hi_c = (tcv > FDM1) ? FDM1 : tcv;
    end else begin
      lo_c = tcv;
      hi_c = colv - 12'sd1;
    end
    pt_addr   = AW'(row_i) * FDA + AW'(colv[CW-1:0]);
    fill_addr = AW'(prow_r) * FDA + AW'(fcol_r[CW-1:0]);
    last_pt   = pt_r == 3'd7;

    mem_raddr = pt_addr;
    mem_we    = 1'b0;
    mem_waddr = paddr_r;
    mem_wdata = shade_r;
    if (state_r == P_PTCHK && mem_rdata != PIX_FULL) begin
      mem_we = 1'b1;
    end else if (state_r == P_FILL) begin
      mem_we    = 1'b1;
      mem_waddr = fill_addr;
      mem_wdata = PIX_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == P_NEXT) && (left_r == 11'd0);
      unique case (state_r)
        P_IDLE: begin
          if (cmd.start) begin
            state_r <= (dm_c != 10'd0) ? P_SEGDIV : P_STAMP;
          end
        end
        P_SEGDIV: begin
          if (div_done) begin
            state_r <= P_STAMP;
          end
        end
        P_STAMP: begin
          state_r <= (rad_r == 6'd0) ? P_NEXT : P_SHST;
        end
        P_SHST: begin
          state_r <= P_SHWAIT;
        end
        P_SHWAIT: begin
          if (div_done) begin
            state_r <= P_PTRD;
          end
        end
        P_PTRD: begin
          if (row_ok && col_ok) begin
            state_r <= P_PTCHK;
          end else if (!last_pt) begin
            state_r <= P_PTRD;
          end else begin
            state_r <= (xn >= y1) ? P_SHST : P_NEXT;
          end
        end
        P_PTCHK: begin
          if (mem_rdata != PIX_FULL && fcol_r <= fhi_r) begin
            state_r <= P_FILL;
          end else if (!last_pt) begin
            state_r <= P_PTRD;
          end else begin
            state_r <= (xn >= y1) ? P_SHST : P_NEXT;
          end
        end
        P_FILL: begin
          if (fcol_r == fhi_r) begin
            if (!last_pt) begin
              state_r <= P_PTRD;
            end else begin
              state_r <= (xn >= y1) ? P_SHST : P_NEXT;
            end
          end
        end
        P_NEXT: begin
          if (left_r == 11'd0) begin
            state_r <= P_IDLE;
          end else begin
            state_r <= P_STAMP;
          end
        end
        default: state_r <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      P_IDLE: begin
        vmaj_r    <= vmaj_c;
        dir_neg_r <= vmaj_c ? dv[10] : du[10];
        min_neg_r <= vmaj_c ? du[10] : dv[10];
        dm_r      <= dm_c;
        maj_r     <= vmaj_c ? cmd.sv : cmd.su;
        smin_r    <= vmaj_c ? cmd.su : cmd.sv;
        left_r    <= {1'b0, dm_c};
        rad_r     <= cmd.radius;
        q_r       <= '0;
        rem_r     <= '0;
        qa_r      <= '0;
        ra_r      <= '0;
      end
      P_SEGDIV: begin
        if (div_done) begin
          qa_r <= div_q[16:0];
          ra_r <= div_r;
        end
      end
      P_STAMP: begin
        rc_r  <= rc_c;
        cc_r  <= cc_c;
        x_r   <= $signed({6'b0, rad_r});
        y_r   <= 12'sd0;
        err_r <= 12'sd0;
      end
      P_SHST: begin
        pt_r <= 3'd0;
      end
      P_SHWAIT: begin
        if (div_done) begin
          shade_r <= (div_q > DIV_NW'(255)) ? PIX_FULL : div_q[7:0];
        end
      end
      P_PTRD: begin
        prow_r  <= row_i;
        paddr_r <= pt_addr;
        fcol_r  <= lo_c;
        fhi_r   <= hi_c;
        if (!(row_ok && col_ok)) begin
          pt_r <= pt_r + 3'd1;
          if (last_pt) begin
            x_r <= xn; y_r <= y1; err_r <= en;
          end
        end
      end
      P_PTCHK: begin
        if (!(mem_rdata != PIX_FULL && fcol_r <= fhi_r)) begin
          pt_r <= pt_r + 3'd1;
          if (last_pt) begin
            x_r <= xn; y_r <= y1; err_r <= en;
          end
        end
      end
      P_FILL: begin
        fcol_r <= fcol_r + 12'sd1;
        if (fcol_r == fhi_r) begin
          pt_r <= pt_r + 3'd1;
          if (last_pt) begin
            x_r <= xn; y_r <= y1; err_r <= en;
          end
        end
      end
      P_NEXT: begin
        if (left_r != 11'd0) begin
          left_r <= left_r - 11'd1;
          maj_r  <= dir_neg_r ? maj_r - 10'd1 : maj_r + 10'd1;
          q_r    <= q_r + 27'(qa_r) + 27'(carry);
          rem_r  <= carry ? 10'(sum_rem - {1'b0, dm_r}) : sum_rem[9:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign done = done_r;

endmodule

`default_nettype wire

### sim/tb_bsr_if_note.sv
// ----------------------------------------------------------------------------
// tb_bsr_types
// Command and result records shared by the rasteriser testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package tb_bsr_types;
  import bsr_pkg::*;

  typedef struct {
    op_t      op;
    bit [9:0] su;
    bit [9:0] sv;
    bit [9:0] eu;
    bit [9:0] ev;
    bit [8:0] prow;
    bit [8:0] pcol;
    bit       fixed;
    bit [7:0] fix_val;
    bit       fix_rd;
  } brush_cmd_t;

  typedef struct {
    bit [7:0] pixel_value;
    bit       is_read;
  } pixel_result_t;

endpackage

### sim/tb_brush_stroke_rasterizer_top.sv
// ----------------------------------------------------------------------------
// tb_brush_stroke_rasterizer_top
// Self-checking bench for the brush stroke rasteriser: a directed table of
// commands and radius extremes, then random short strokes and pixel reads
// under several radii, checked against a frame store model or fixed values.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_brush_stroke_rasterizer_top;
  import bsr_pkg::*;
  import tb_bsr_types::*;

  localparam int DIM = 512;
  localparam longint ONE_Q = 65536;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bsr_in_if  in_ch ();
  bsr_out_if out_ch ();

  brush_stroke_rasterizer_top #(.FRAME_DIM(DIM)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  logic [7:0]    pix_mem [0:DIM*DIM-1];
  int            model_radius;
  pixel_result_t result_q[$];
  int            err_cnt = 0;
  bit            idle_en = 1'b1;
  int            hold_left = 0;
  int            stall_left = 0;
  int            last_row = 256;
  int            last_col = 256;

  initial begin
    #200_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  // ---- frame store model
  function automatic void paint_point(longint rc, longint cc, longint dr, longint dc,
                                      logic [7:0] shade);
    longint row, col, tc, i;
    row = (rc + dr * ONE_Q) / ONE_Q;
    col = (cc + dc * ONE_Q) / ONE_Q;
    tc  = cc / ONE_Q;
    if (row < 0 || row >= DIM || col < 0 || col >= DIM) return;
    if (pix_mem[row*DIM + col] == PIX_FULL) return;
    pix_mem[row*DIM + col] = shade;
    if (dc >= 0) begin
      for (i = (tc < 0 ? 0 : tc); i < col; i++) pix_mem[row*DIM + i] = PIX_FULL;
    end else begin
      for (i = (tc > DIM-1 ? DIM-1 : tc); i > col; i--) pix_mem[row*DIM + i] = PIX_FULL;
    end
  endfunction

  function automatic void stamp_disk(longint rc, longint cc);
    longint r, x, y, e, v;
    logic [7:0] shade;
    r = model_radius;
    x = r;
    y = 0;
    e = 0;
    if (r == 0) return;
    while (x >= y) begin
      v = ((r - e) * 255) / r;
      shade = (v < 0) ? 8'd0 : (v > 255 ? 8'd255 : v[7:0]);
      paint_point(rc, cc, x, y, shade);
      paint_point(rc, cc, y, x, shade);
      paint_point(rc, cc, -y, x, shade);
      paint_point(rc, cc, -x, y, shade);
      paint_point(rc, cc, -x, -y, shade);
      paint_point(rc, cc, -y, -x, shade);
      paint_point(rc, cc, y, -x, shade);
      paint_point(rc, cc, x, -y, shade);
      y += 1;
      e += 1 + 2*y;
      if (2*(e - x) + 1 > 0) begin
        x -= 1;
        e += 1 - 2*x;
      end
    end
  endfunction

  function automatic void draw_stroke(longint su, longint sv, longint eu, longint ev);
    longint du, dv, adu, adv, i, dir, q;
    du = eu - su;
    dv = ev - sv;
    adu = du < 0 ? -du : du;
    adv = dv < 0 ? -dv : dv;
    if (du == 0 && dv == 0) begin
      stamp_disk(DIM*ONE_Q - sv*ONE_Q, su*ONE_Q);
      return;
    end
    if (adu < adv) begin
      dir = dv > 0 ? 1 : -1;
      for (i = sv; ; i += dir) begin
        q = su*ONE_Q + (du*(i - sv)*ONE_Q) / dv;
        stamp_disk((DIM - i)*ONE_Q, q);
        if (i == ev) break;
      end
    end else begin
      dir = du > 0 ? 1 : -1;
      for (i = su; ; i += dir) begin
        q = sv*ONE_Q + (dv*(i - su)*ONE_Q) / du;
        stamp_disk(DIM*ONE_Q - q, i*ONE_Q);
        if (i == eu) break;
      end
    end
  endfunction

  function automatic pixel_result_t apply_cmd(brush_cmd_t c);
    pixel_result_t r;
    r.pixel_value = 8'd0;
    r.is_read = 1'b0;
    case (c.op)
      OP_CLEAR: foreach (pix_mem[k]) pix_mem[k] = 8'd0;
      OP_DRAW:  draw_stroke(c.su, c.sv, c.eu, c.ev);
      OP_READ: begin
        r.pixel_value = pix_mem[c.prow*DIM + c.pcol];
        r.is_read = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---- result side
  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected transfer", out_ch.pixel_value, 0);
      end else begin
        want = result_q.pop_front();
        if (out_ch.pixel_value !== want.pixel_value)
          report_mismatch("pixel_value", out_ch.pixel_value, want.pixel_value);
        if (out_ch.is_read !== want.is_read)
          report_mismatch("is_read", out_ch.is_read, want.is_read);
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // ---- command side
  task automatic send_cmd(input brush_cmd_t c);
    pixel_result_t r;
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= c.op;
    in_ch.start_u   <= c.su;
    in_ch.start_v   <= c.sv;
    in_ch.end_u     <= c.eu;
    in_ch.end_v     <= c.ev;
    in_ch.pixel_row <= c.prow;
    in_ch.pixel_col <= c.pcol;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = apply_cmd(c);
    if (c.fixed) begin
      r.pixel_value = c.fix_val;
      r.is_read = c.fix_rd;
    end
    result_q.push_back(r);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_radius(input int value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(REG_BRUSH_RADIUS * 4);
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model_radius = value & 63;
  endtask

  function automatic brush_cmd_t mk(op_t op, int su, int sv, int eu, int ev,
                                    int prow, int pcol);
    brush_cmd_t c;
    c.op = op;
    c.su = su;
    c.sv = sv;
    c.eu = eu;
    c.ev = ev;
    c.prow = prow;
    c.pcol = pcol;
    c.fixed = 1'b0;
    c.fix_val = 8'd0;
    c.fix_rd = 1'b0;
    return c;
  endfunction

  function automatic brush_cmd_t mk_fixed(brush_cmd_t c, int val, bit rd);
    c.fixed = 1'b1;
    c.fix_val = val;
    c.fix_rd = rd;
    return c;
  endfunction

  function automatic int clamp_pix(int v);
    return v < 0 ? 0 : (v > DIM-1 ? DIM-1 : v);
  endfunction

  function automatic brush_cmd_t rand_cmd();
    int sel, su, sv;
    brush_cmd_t c;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      if ($urandom_range(0, 4) == 0) begin
        su = $urandom_range(0, 1023);
        sv = $urandom_range(0, 1023);
      end else begin
        su = $urandom_range(0, DIM-1);
        sv = $urandom_range(1, DIM);
      end
      c = mk(OP_DRAW, su, sv, (su + $urandom_range(0, 12) - 6) & 1023,
             (sv + $urandom_range(0, 12) - 6) & 1023,
             $urandom_range(0, 511), $urandom_range(0, 511));
      if (su < DIM && sv <= DIM) begin
        last_col = su;
        last_row = DIM - sv;
      end
    end else if (sel < 95) begin
      c = mk(OP_READ, $urandom_range(0, 1023), $urandom_range(0, 1023),
             $urandom_range(0, 1023), $urandom_range(0, 1023),
             clamp_pix(last_row + $urandom_range(0, 2*model_radius+2) - model_radius - 1),
             clamp_pix(last_col + $urandom_range(0, 2*model_radius+2) - model_radius - 1));
    end else begin
      c = mk(OP_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
             $urandom_range(0, 1023), $urandom_range(0, 1023),
             $urandom_range(0, 511), $urandom_range(0, 511));
      c = mk_fixed(c, 0, 1'b0);
    end
    return c;
  endfunction

  initial begin
    brush_cmd_t dir_rows[$];
    int rad_set[4];
    in_ch.valid = 1'b0;
    in_ch.op = OP_CLEAR;
    in_ch.start_u = '0;
    in_ch.start_v = '0;
    in_ch.end_u = '0;
    in_ch.end_v = '0;
    in_ch.pixel_row = '0;
    in_ch.pixel_col = '0;
    out_ch.ready = 1'b0;
    foreach (pix_mem[k]) pix_mem[k] = 8'd0;
    model_radius = RADIUS_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    dir_rows.push_back(mk_fixed(mk(OP_READ, 0, 0, 0, 0, 0, 0), 0, 1'b1));
    dir_rows.push_back(mk_fixed(mk(OP_READ, 1023, 1023, 1023, 1023, 511, 511), 0, 1'b1));
    dir_rows.push_back(mk(OP_DRAW, 256, 256, 256, 256, 0, 0));
    dir_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 256, 256));
    dir_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 256, 266));
    dir_rows.push_back(mk(OP_DRAW, 100, 100, 104, 100, 0, 0));
    dir_rows.push_back(mk(OP_DRAW, 300, 50, 302, 57, 0, 0));
    dir_rows.push_back(mk(OP_DRAW, 20, 400, 14, 403, 0, 0));
    dir_rows.push_back(mk(OP_DRAW, 1023, 1023, 1020, 1021, 0, 0));
    dir_rows.push_back(mk(OP_DRAW, 0, 0, 0, 2, 0, 0));
    dir_rows.push_back(mk(OP_DRAW, 508, 5, 511, 1, 0, 0));
    dir_rows.push_back(mk_fixed(mk(OP_NONE, 1023, 1023, 1023, 1023, 511, 511), 0, 1'b0));
    dir_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 511, 0));
    dir_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 412, 100));
    dir_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 110, 17));
    dir_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 458, 301));
    dir_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 507, 510));
    dir_rows.push_back(mk_fixed(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0), 0, 1'b0));
    dir_rows.push_back(mk_fixed(mk(OP_READ, 0, 0, 0, 0, 256, 256), 0, 1'b1));
    foreach (dir_rows[k]) send_cmd(dir_rows[k]);
    wait_drain();

    // radius extremes: widest disk, then a one-pixel radius, then none
    write_radius(63);
    send_cmd(mk(OP_DRAW, 200, 300, 200, 300, 0, 0));
    send_cmd(mk(OP_READ, 0, 0, 0, 0, 212, 200));
    send_cmd(mk(OP_READ, 0, 0, 0, 0, 212, 262));
    send_cmd(mk(OP_READ, 0, 0, 0, 0, 149, 200));
    wait_drain();
    write_radius(1);
    send_cmd(mk(OP_DRAW, 40, 40, 45, 38, 0, 0));
    send_cmd(mk(OP_READ, 0, 0, 0, 0, 472, 41));
    wait_drain();
    write_radius(0);
    send_cmd(mk(OP_DRAW, 200, 300, 201, 302, 0, 0));
    send_cmd(mk(OP_READ, 0, 0, 0, 0, 212, 200));
    wait_drain();

    rad_set[0] = $urandom_range(2, 8);
    rad_set[1] = $urandom_range(1, 20);
    rad_set[2] = 1;
    rad_set[3] = $urandom_range(5, 14);
    for (int ph = 0; ph < 4; ph++) begin
      write_radius(rad_set[ph]);
      for (int n = 0; n < 25; n++) begin
        if (ph == 1 && n == 5) hold_left = 3000;
        if (ph == 2 && n == 10) wait_drain();
        if (ph == 3 && n == 5) idle_en = 1'b0;
        send_cmd(rand_cmd());
      end
      wait_drain();
    end

    in_ch.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### brush_stroke_rasterizer_top.f
rtl/bsr_pkg.sv
rtl/bsr_if.sv
rtl/bsr_div.sv
rtl/bsr_frame_store.sv
rtl/bsr_pen.sv
rtl/brush_stroke_rasterizer_top.sv
sim/tb_bsr_if_note.sv
sim/tb_brush_stroke_rasterizer_top.sv
